>>> rtl/sik_pkg.sv
// Shared constants, types and the arctangent table for the swerve drive
// inverse kinematics block. No dependencies.
package sik_pkg;

  localparam int unsigned WheelCount       = 4;
  localparam int unsigned CordicIterations = 16;
  localparam int unsigned AtanTableLen     = 24;

  // Square root: one result bit per stage, radicand twice as wide
  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned RadW      = 2 * SqrtSteps;

  // Angle constants, Q16 radians
  localparam int Q16Pi     = 205887;
  localparam int Q16HalfPi = 102944;
  localparam int Q16TwoPi  = 411774;

  // CORDIC datapath widths
  localparam int unsigned CxW = 34;
  localparam int unsigned ZW  = 24;

  // Wrap to [-pi, pi): bias keeps the dividend positive, multiple of 2pi
  localparam longint WrapOffset = longint'(Q16TwoPi) * 32768 + longint'(Q16Pi);
  localparam longint RecipTwoPi = (longint'(1) << 35) / longint'(Q16TwoPi);

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] RegOffset0   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegOffset1   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegOffset2   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegOffset3   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegInvRadius = 3'd4;
  localparam logic [15:0] InvRadiusReset = 16'd5120;

  // Lane timing, in registers after the request is taken
  localparam int unsigned SpeedLatency = 4 + SqrtSteps;
  localparam int unsigned AngleLatency = 9 + CordicIterations;
  localparam int unsigned AlignDelay   = SpeedLatency - AngleLatency;
  localparam int unsigned TotalLatency = SpeedLatency + 1;

  typedef struct packed {
    logic signed [ZW-1:0] z;
    logic signed [31:0]   cur;
    logic                 zero;
  } cordic_res_t;

  typedef struct packed {
    logic signed [31:0] goal;
    logic               flip;
    logic [29:0]        speed;
  } lane_res_t;

  function automatic logic [15:0] atan_q16(input int unsigned i);
    logic [15:0] v;
    case (i)
      0:       v = 16'd51472;
      1:       v = 16'd30386;
      2:       v = 16'd16055;
      3:       v = 16'd8150;
      4:       v = 16'd4091;
      5:       v = 16'd2047;
      6:       v = 16'd1024;
      7:       v = 16'd512;
      8:       v = 16'd256;
      9:       v = 16'd128;
      10:      v = 16'd64;
      11:      v = 16'd32;
      12:      v = 16'd16;
      13:      v = 16'd8;
      14:      v = 16'd4;
      15:      v = 16'd2;
      16:      v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/sik_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on sik_pkg.
module sik_sqrt (
  input  logic                          clk_i,
  input  logic [sik_pkg::RadW-1:0]      rad_i,
  output logic [sik_pkg::SqrtSteps-1:0] root_o
);
  import sik_pkg::*;

  localparam int unsigned RemW = SqrtSteps + 1;

  logic [RadW-1:0]      rad_q  [SqrtSteps];
  logic [RemW-1:0]      rem_q  [SqrtSteps];
  logic [SqrtSteps-1:0] root_q [SqrtSteps];

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_step
    logic [RadW-1:0]      rad_in;
    logic [RemW-1:0]      rem_in;
    logic [SqrtSteps-1:0] root_in;
    logic [RemW+1:0]      rem_sh;
    logic [RemW+1:0]      trial;
    logic                 ge;

    if (k == 0) begin : g_first
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    assign rem_sh = {rem_in, rad_in[RadW-1 -: 2]};
    assign trial  = {1'b0, root_in, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk_i) begin
      rad_q[k]  <= {rad_in[RadW-3:0], 2'b00};
      rem_q[k]  <= ge ? RemW'(rem_sh - trial) : RemW'(rem_sh);
      root_q[k] <= {root_in[SqrtSteps-2:0], ge};
    end
  end

  assign root_o = root_q[SqrtSteps-1];

endmodule

>>> rtl/sik_cordic.sv
// Pipelined atan2: two-stage normalising shift, quadrant fold, then one
// vectoring iteration per stage. Depends on sik_pkg.
module sik_cordic (
  input  logic                        clk_i,
  input  logic signed [31:0]          x_i,
  input  logic signed [31:0]          y_i,
  input  logic signed [31:0]          cur_i,
  input  logic                        zero_i,
  output sik_pkg::cordic_res_t        res_o
);
  import sik_pkg::*;

  // stage 1: magnitude bits for the shift search
  logic [31:0]        ax, ay;
  logic signed [31:0] x1_q, y1_q, cur1_q;
  logic               zero1_q;
  logic [30:0]        mag1_q;

  assign ax = x_i[31] ? 32'(-x_i) : x_i;
  assign ay = y_i[31] ? 32'(-y_i) : y_i;

  always_ff @(posedge clk_i) begin
    x1_q    <= x_i;
    y1_q    <= y_i;
    cur1_q  <= cur_i;
    zero1_q <= zero_i;
    mag1_q  <= ax[30:0] | ay[30:0];
  end

  // stage 2: shift count so that the larger part reaches bit 30
  logic [4:0]         shamt_d, shamt2_q;
  logic signed [31:0] x2_q, y2_q, cur2_q;
  logic               zero2_q;

  always_comb begin
    shamt_d = '0;
    for (int b = 0; b < 31; b++) begin
      if (mag1_q[b]) shamt_d = 5'(30 - b);
    end
  end

  always_ff @(posedge clk_i) begin
    x2_q     <= x1_q;
    y2_q     <= y1_q;
    cur2_q   <= cur1_q;
    zero2_q  <= zero1_q;
    shamt2_q <= shamt_d;
  end

  // stage 3: shift and fold the left half-plane onto the right
  logic signed [31:0]    xs, ys;
  logic signed [CxW-1:0] x3_d, y3_d, x3_q, y3_q;
  logic signed [ZW-1:0]  z3_d, z3_q;
  logic signed [31:0]    cur3_q;
  logic                  zero3_q;

  assign xs = x2_q <<< shamt2_q;
  assign ys = y2_q <<< shamt2_q;

  always_comb begin
    if (xs[31]) begin
      x3_d = -{{(CxW-32){xs[31]}}, xs};
      y3_d = -{{(CxW-32){ys[31]}}, ys};
      z3_d = ys[31] ? -ZW'(Q16Pi) : ZW'(Q16Pi);
    end else begin
      x3_d = {{(CxW-32){xs[31]}}, xs};
      y3_d = {{(CxW-32){ys[31]}}, ys};
      z3_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    x3_q    <= x3_d;
    y3_q    <= y3_d;
    z3_q    <= z3_d;
    cur3_q  <= cur2_q;
    zero3_q <= zero2_q;
  end

  logic signed [CxW-1:0] cx_q   [CordicIterations];
  logic signed [CxW-1:0] cy_q   [CordicIterations];
  logic signed [ZW-1:0]  cz_q   [CordicIterations];
  logic signed [31:0]    ccur_q [CordicIterations];
  logic                  czero_q[CordicIterations];

  for (genvar i = 0; i < CordicIterations; i++) begin : g_iter
    logic signed [CxW-1:0] x_in, y_in, dx, dy;
    logic signed [ZW-1:0]  z_in, ang;
    logic signed [31:0]    cur_in;
    logic                  zero_in;

    if (i == 0) begin : g_first
      assign x_in    = x3_q;
      assign y_in    = y3_q;
      assign z_in    = z3_q;
      assign cur_in  = cur3_q;
      assign zero_in = zero3_q;
    end else begin : g_next
      assign x_in    = cx_q[i-1];
      assign y_in    = cy_q[i-1];
      assign z_in    = cz_q[i-1];
      assign cur_in  = ccur_q[i-1];
      assign zero_in = czero_q[i-1];
    end

    assign dx  = y_in >>> i;
    assign dy  = x_in >>> i;
    assign ang = {{(ZW-16){1'b0}}, atan_q16(i)};

    always_ff @(posedge clk_i) begin
      if (!y_in[CxW-1]) begin
        cx_q[i] <= x_in + dx;
        cy_q[i] <= y_in - dy;
        cz_q[i] <= z_in + ang;
      end else begin
        cx_q[i] <= x_in - dx;
        cy_q[i] <= y_in + dy;
        cz_q[i] <= z_in - ang;
      end
      ccur_q[i]  <= cur_in;
      czero_q[i] <= zero_in;
    end
  end

  assign res_o.z    = cz_q[CordicIterations-1];
  assign res_o.cur  = ccur_q[CordicIterations-1];
  assign res_o.zero = czero_q[CordicIterations-1];

endmodule

>>> rtl/sik_lane.sv
// One wheel: module velocity, speed via square root, heading via CORDIC,
// wrap and nearest transposition. Depends on sik_pkg, sik_sqrt, sik_cordic.
module sik_lane (
  input  logic                clk_i,
  input  logic signed [15:0]  vx_i,
  input  logic signed [15:0]  vy_i,
  input  logic signed [15:0]  w_i,
  input  logic signed [31:0]  cur_i,
  input  logic [31:0]         offset_i,
  input  logic [15:0]         inv_radius_i,
  output sik_pkg::lane_res_t  res_o
);
  import sik_pkg::*;

  localparam logic signed [20:0] PiA     = 21'(Q16Pi);
  localparam logic signed [20:0] HalfPiA = 21'(Q16HalfPi);
  localparam logic [19:0]        TwoPiA  = 20'(Q16TwoPi);

  // module velocity, Q.26
  logic signed [15:0] ox, oy;
  logic signed [31:0] wox, woy;
  logic signed [32:0] mx_d, my_d;
  logic signed [31:0] mx_q, my_q, cur1_q;
  logic               zero1_q;

  assign ox   = signed'(offset_i[15:0]);
  assign oy   = signed'(offset_i[31:16]);
  assign wox  = w_i * ox;
  assign woy  = w_i * oy;
  assign mx_d = {{3{vx_i[15]}}, vx_i, 14'd0} - {woy[31], woy};
  assign my_d = {{3{vy_i[15]}}, vy_i, 14'd0} + {wox[31], wox};

  always_ff @(posedge clk_i) begin
    mx_q    <= mx_d[31:0];
    my_q    <= my_d[31:0];
    cur1_q  <= cur_i;
    zero1_q <= (mx_d == '0) && (my_d == '0);
  end

  // speed path
  logic signed [63:0]   sqx_d, sqy_d;
  logic [61:0]          sqx_q, sqy_q;
  logic [62:0]          sum_q;
  logic [SqrtSteps-1:0] root;
  logic [47:0]          spd_prod;
  logic [29:0]          spd_q;

  assign sqx_d = mx_q * mx_q;
  assign sqy_d = my_q * my_q;

  always_ff @(posedge clk_i) begin
    sqx_q <= sqx_d[61:0];
    sqy_q <= sqy_d[61:0];
    sum_q <= {1'b0, sqx_q} + {1'b0, sqy_q};
  end

  sik_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rad_i  ({1'b0, sum_q}),
    .root_o (root)
  );

  assign spd_prod = root * inv_radius_i;

  always_ff @(posedge clk_i) begin
    spd_q <= spd_prod[47:18];
  end

  // heading path
  cordic_res_t cres;

  sik_cordic u_cordic (
    .clk_i  (clk_i),
    .x_i    (mx_q),
    .y_i    (my_q),
    .cur_i  (cur1_q),
    .zero_i (zero1_q),
    .res_o  (cres)
  );

  // wrap: t = change + pi + bias, then t mod 2pi by reciprocal
  logic signed [32:0] head, chg;
  logic [34:0]        t_q, t2_q, qd;
  logic [51:0]        qp;
  logic [16:0]        q_q;
  logic [19:0]        r_q, r2;
  logic signed [20:0] d_q, e;
  logic signed [31:0] cw1_q, cw2_q, cw3_q, cw4_q;
  logic signed [32:0] gsum;
  logic signed [31:0] goal_d, goal_q;
  logic               flip_d, flip_q;

  assign head = cres.zero ? {cres.cur[31], cres.cur}
                          : {{(33-ZW){cres.z[ZW-1]}}, cres.z};
  assign chg  = head - {cres.cur[31], cres.cur};
  assign qp   = t_q * 17'(RecipTwoPi);
  assign qd   = 35'(q_q) * 35'(Q16TwoPi);
  assign r2   = (r_q >= TwoPiA) ? r_q - TwoPiA : r_q;

  always_ff @(posedge clk_i) begin
    t_q   <= {{2{chg[32]}}, chg} + 35'(WrapOffset);
    cw1_q <= cres.cur;
    q_q   <= qp[51:35];
    t2_q  <= t_q;
    cw2_q <= cw1_q;
    r_q   <= 20'(t2_q - qd);
    cw3_q <= cw2_q;
    d_q   <= signed'({1'b0, r2}) - PiA;
    cw4_q <= cw3_q;
  end

  // nearest transposition
  always_comb begin
    if (d_q >= -HalfPiA && d_q <= HalfPiA) begin
      e      = d_q;
      flip_d = 1'b0;
    end else begin
      e      = d_q[20] ? d_q + PiA : d_q - PiA;
      flip_d = 1'b1;
    end
    gsum = {cw4_q[31], cw4_q} + {{12{e[20]}}, e};
    if (gsum[32] != gsum[31]) begin
      goal_d = gsum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      goal_d = gsum[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    goal_q <= goal_d;
    flip_q <= flip_d;
  end

  // line the angle result up with the speed
  logic signed [31:0] goal_al_q [AlignDelay];
  logic               flip_al_q [AlignDelay];

  always_ff @(posedge clk_i) begin
    goal_al_q[0] <= goal_q;
    flip_al_q[0] <= flip_q;
    for (int s = 1; s < AlignDelay; s++) begin
      goal_al_q[s] <= goal_al_q[s-1];
      flip_al_q[s] <= flip_al_q[s-1];
    end
  end

  assign res_o.goal  = goal_al_q[AlignDelay-1];
  assign res_o.flip  = flip_al_q[AlignDelay-1];
  assign res_o.speed = spd_q;

endmodule

>>> rtl/swerve_inverse_kinematics.sv
// Swerve inverse kinematics: four wheel lanes in parallel plus an output stage.
// Throughput: one request per cycle; busy_o stays low, done_o cannot be held off.
// The lanes are fully pipelined: a 32-stage square root and a 16-step CORDIC.
// Reset clears the pipeline valid bits and restores the register defaults.
// Depends on sik_pkg and sik_lane.
module swerve_inverse_kinematics (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic                         wr_en_i,
  input  logic [sik_pkg::CfgIdxW-1:0]  wr_idx_i,
  input  logic [31:0]                  wr_data_i,
  input  logic signed [15:0]           command_vx_i,
  input  logic signed [15:0]           command_vy_i,
  input  logic signed [15:0]           command_yaw_rate_i,
  input  logic signed [31:0]           current_angle_0_i,
  input  logic signed [31:0]           current_angle_1_i,
  input  logic signed [31:0]           current_angle_2_i,
  input  logic signed [31:0]           current_angle_3_i,
  output logic                         done_o,
  output logic signed [31:0]           goal_angle_0_o,
  output logic signed [31:0]           goal_angle_1_o,
  output logic signed [31:0]           goal_angle_2_o,
  output logic signed [31:0]           goal_angle_3_o,
  output logic signed [31:0]           wheel_speed_0_o,
  output logic signed [31:0]           wheel_speed_1_o,
  output logic signed [31:0]           wheel_speed_2_o,
  output logic signed [31:0]           wheel_speed_3_o
);
  import sik_pkg::*;

  // configuration
  logic [31:0] offset_q [WheelCount];
  logic [15:0] inv_radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < WheelCount; k++) offset_q[k] <= '0;
      inv_radius_q <= InvRadiusReset;
    end else if (wr_en_i) begin
      case (wr_idx_i)
        RegOffset0:   offset_q[0]  <= wr_data_i;
        RegOffset1:   offset_q[1]  <= wr_data_i;
        RegOffset2:   offset_q[2]  <= wr_data_i;
        RegOffset3:   offset_q[3]  <= wr_data_i;
        RegInvRadius: inv_radius_q <= wr_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  logic accept;
  assign accept = start_i && !busy_o;

  // request valid through the lanes
  logic [SpeedLatency-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[SpeedLatency-2:0], accept};
    end
  end

  logic signed [31:0] cur [WheelCount];
  lane_res_t          lres [WheelCount];

  assign cur[0] = current_angle_0_i;
  assign cur[1] = current_angle_1_i;
  assign cur[2] = current_angle_2_i;
  assign cur[3] = current_angle_3_i;

  for (genvar k = 0; k < WheelCount; k++) begin : g_lane
    sik_lane u_lane (
      .clk_i        (clk_i),
      .vx_i         (command_vx_i),
      .vy_i         (command_vy_i),
      .w_i          (command_yaw_rate_i),
      .cur_i        (cur[k]),
      .offset_i     (offset_q[k]),
      .inv_radius_i (inv_radius_q),
      .res_o        (lres[k])
    );
  end

  // merge: output register, speed sign applied here
  logic               done_q;
  logic signed [31:0] goal_q  [WheelCount];
  logic signed [31:0] speed_q [WheelCount];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q[SpeedLatency-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_q[SpeedLatency-1]) begin
      for (int k = 0; k < WheelCount; k++) begin
        goal_q[k]  <= lres[k].goal;
        speed_q[k] <= lres[k].flip ? -signed'({2'b00, lres[k].speed})
                                   :  signed'({2'b00, lres[k].speed});
      end
    end
  end

  assign done_o          = done_q;
  assign goal_angle_0_o  = goal_q[0];
  assign goal_angle_1_o  = goal_q[1];
  assign goal_angle_2_o  = goal_q[2];
  assign goal_angle_3_o  = goal_q[3];
  assign wheel_speed_0_o = speed_q[0];
  assign wheel_speed_1_o = speed_q[1];
  assign wheel_speed_2_o = speed_q[2];
  assign wheel_speed_3_o = speed_q[3];

  a_done_has_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, TotalLatency))
    else $error("result without a matching request");

  a_request_completes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##TotalLatency done_o)
    else $error("request did not produce a result");

  a_inv_radius_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) && $past(wr_en_i) && $past(wr_idx_i) == RegInvRadius
      |-> inv_radius_q == $past(wr_data_i[15:0]))
    else $error("inverse radius write lost");

endmodule
